FILE: sv/hcmk_pkg.sv
// ----------------------------------------------------------------------------
// hcmk_pkg
// Shared types, constants and lookup functions for the hex and character
// Morse keyer: queue entry layout, Morse unit table, hex digit mapping.
// ----------------------------------------------------------------------------
package hcmk_pkg;

  // Width of one on/off unit pattern
  localparam int PATTERN_BITS = 19;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes of the configuration port
  localparam logic CFG_CHAR_GAP = 1'b0;
  localparam logic CFG_BYTE_GAP = 1'b1;

  // Reset values of the gap registers
  localparam logic [3:0] CHAR_GAP_RESET = 4'd3;
  localparam logic [7:0] BYTE_GAP_RESET = 8'd7;

  // Item actions
  localparam logic ACT_HEX  = 1'b0;
  localparam logic ACT_CHAR = 1'b1;

  // One character job for the back part
  typedef struct packed {
    logic [PATTERN_BITS-1:0] pattern;   // units, LSB first, ends at top set bit
    logic                    byte_gap;  // add the byte blank after the char gap
    logic                    last;      // final job of its item
  } entry_t;

  // Queue status seen by the producer and the consumer
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Unit patterns: digits 0-9, then letters A-Z
  localparam logic [31:0] MORSE_TABLE [36] = '{
    32'h77777, 32'h1DDDD, 32'h07775, 32'h01DD5, 32'h00755,
    32'h00155, 32'h00557, 32'h01577, 32'h05777, 32'h17777,
    32'h0001D, 32'h00157, 32'h005D7, 32'h00057, 32'h00001,
    32'h00175, 32'h00177, 32'h00055, 32'h00005, 32'h01DDD,
    32'h001D7, 32'h0015D, 32'h00077, 32'h00017, 32'h00777,
    32'h005DD, 32'h01D77, 32'h0005D, 32'h00015, 32'h00007,
    32'h00075, 32'h001D5, 32'h001DD, 32'h00757, 32'h01DD7,
    32'h00577
  };

  // Map an ASCII code to its unit pattern; unknown codes give zero
  function automatic logic [PATTERN_BITS-1:0] pattern_of(input logic [7:0] code);
    logic [7:0] up;
    logic [7:0] idx;
    logic       hit;
    up  = (code >= 8'h61 && code <= 8'h7A) ? code - 8'd32 : code;
    hit = 1'b0;
    idx = 8'd0;
    if (up >= 8'h30 && up <= 8'h39) begin
      hit = 1'b1;
      idx = up - 8'h30;
    end else if (up >= 8'h41 && up <= 8'h5A) begin
      hit = 1'b1;
      idx = up - 8'h41 + 8'd10;
    end
    if (hit) begin
      return MORSE_TABLE[idx[5:0]][PATTERN_BITS-1:0];
    end
    return '0;
  endfunction

  // Uppercase ASCII hex digit of a nibble
  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 8'h30 + {4'd0, nib};
    end
    return 8'h37 + {4'd0, nib};
  endfunction

endpackage

FILE: sv/hex_and_char_morse_keyer_top.sv
// ----------------------------------------------------------------------------
// hex_and_char_morse_keyer_top
// Morse keyer for hex bytes and ASCII characters with key/hold results.
// ----------------------------------------------------------------------------
// Each item either sends a byte as two uppercase hex digits (action 0) or one
// ASCII character (action 1). Each result gives a key level and the number of
// time units to hold it; last marks the final result of an item. A character
// gives one result per pattern unit plus the character gap, at most 20
// results; a hex byte gives at most 41. The back sequencer pops one job from
// the queue while idle and then sends one result per cycle while the result
// channel does not stall. The front takes a new item as soon as the queue has
// room and no low hex digit waits, while the back still sends. The gap
// registers sit on a write port that is always ready.
// ----------------------------------------------------------------------------
module hex_and_char_morse_keyer_top
  import hcmk_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic       action,
  input  logic [7:0] data,
  output logic       res_valid,
  input  logic       res_stall,
  output logic       key,
  output logic [7:0] hold_units,
  output logic       last
);

  queue_status_t status;
  logic          push;
  entry_t        push_entry;
  logic          pop;
  entry_t        pop_entry;

  // Classify items into character jobs
  hcmk_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .action     (action),
    .data       (data),
    .status     (status),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decouple front and back
  hcmk_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .status     (status)
  );

  // Send key results
  hcmk_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .status     (status),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .key        (key),
    .hold_units (hold_units),
    .last       (last)
  );

endmodule

FILE: sv/hcmk_queue.sv
// ----------------------------------------------------------------------------
// hcmk_queue
// Short register queue of character jobs between the front and the back.
// ----------------------------------------------------------------------------
module hcmk_queue
  import hcmk_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  entry_t        push_entry,
  input  logic          pop,
  output entry_t        pop_entry,
  output queue_status_t status
);

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign pop_entry    = slots[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!status.full || pop))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

FILE: sv/hcmk_front.sv
// ----------------------------------------------------------------------------
// hcmk_front
// Accepts items, classifies them as hex byte or character and pushes one
// or two character jobs into the queue.
// ----------------------------------------------------------------------------
module hcmk_front
  import hcmk_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  logic          action,
  input  logic [7:0]    data,
  input  queue_status_t status,
  output logic          push,
  output entry_t        push_entry
);

  logic   pend_valid;
  entry_t pend;
  logic   accept;
  entry_t first;
  entry_t second;

  // Hold off new items while the low digit of a hex byte still waits or the queue is full
  assign req_stall = pend_valid || status.full;
  assign accept    = req_valid && !req_stall;

  // Build the jobs of the incoming item
  always_comb begin
    if (action == ACT_CHAR) begin
      first.pattern  = pattern_of(data);
      first.byte_gap = 1'b0;
      first.last     = 1'b1;
    end else begin
      first.pattern  = pattern_of(hex_ascii(data[7:4]));
      first.byte_gap = 1'b0;
      first.last     = 1'b0;
    end
    second.pattern  = pattern_of(hex_ascii(data[3:0]));
    second.byte_gap = 1'b1;
    second.last     = 1'b1;
  end

  assign push       = accept || (pend_valid && !status.full);
  assign push_entry = pend_valid ? pend : first;

  // Keep the second job of a hex byte until the queue has room
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept) begin
      pend_valid <= (action == ACT_HEX);
    end else if (pend_valid && !status.full) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend <= second;
    end
  end

endmodule

FILE: sv/hcmk_back.sv
// ----------------------------------------------------------------------------
// hcmk_back
// Takes character jobs from the queue and sends key results: one unit per
// pattern bit, then the character gap, then the byte blank where asked.
// Holds the gap registers.
// ----------------------------------------------------------------------------
module hcmk_back
  import hcmk_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [7:0]    cfg_data,
  input  queue_status_t status,
  output logic          pop,
  input  entry_t        pop_entry,
  output logic          res_valid,
  input  logic          res_stall,
  output logic          key,
  output logic [7:0]    hold_units,
  output logic          last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_BITS,
    S_CGAP,
    S_BGAP
  } state_t;

  state_t                  state;
  logic [PATTERN_BITS-1:0] pat;
  logic                    job_byte_gap;
  logic                    job_last;
  logic [3:0]              char_gap;
  logic [7:0]              byte_gap;
  logic                    load;
  logic                    emit;
  logic [7:0]              char_hold;
  logic [7:0]              byte_hold;

  assign cfg_ready = 1'b1;
  assign load      = !res_valid || !res_stall;
  assign emit      = load && (state != S_IDLE);
  assign pop       = (state == S_IDLE) && !status.empty;
  assign char_hold = (char_gap == 4'd0) ? 8'd1 : {4'd0, char_gap};
  assign byte_hold = (byte_gap == 8'd0) ? 8'd1 : byte_gap;

  // Sequence results and hold the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      char_gap  <= CHAR_GAP_RESET;
      byte_gap  <= BYTE_GAP_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_CHAR_GAP: char_gap <= cfg_data[3:0];
          CFG_BYTE_GAP: byte_gap <= cfg_data;
          default:      ;
        endcase
      end
      // Raise valid on a new result, drop it once taken
      if (emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            pat          <= pop_entry.pattern;
            job_byte_gap <= pop_entry.byte_gap;
            job_last     <= pop_entry.last;
            state        <= (pop_entry.pattern != '0) ? S_BITS : S_CGAP;
          end
        end
        S_BITS: begin
          if (load) begin
            key        <= pat[0];
            hold_units <= 8'd1;
            last       <= 1'b0;
            pat        <= pat >> 1;
            if ((pat >> 1) == '0) begin
              state <= S_CGAP;
            end
          end
        end
        S_CGAP: begin
          if (load) begin
            key        <= 1'b0;
            hold_units <= char_hold;
            last       <= job_last && !job_byte_gap;
            state      <= job_byte_gap ? S_BGAP : S_IDLE;
          end
        end
        S_BGAP: begin
          if (load) begin
            key        <= 1'b0;
            hold_units <= byte_hold;
            last       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_hold_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (hold_units != 8'd0))
    else $error("result with zero hold");
  a_key_unit: assert property (@(posedge clk) disable iff (rst)
    (res_valid && key) |-> (hold_units == 8'd1))
    else $error("on level held longer than one unit");
  a_bits_left: assert property (@(posedge clk) disable iff (rst)
    (state == S_BITS) |-> (pat != '0))
    else $error("bit state with empty pattern");
`endif

endmodule

FILE: dv/tb_hex_and_char_morse_keyer_top.sv
// ----------------------------------------------------------------------------
// tb_hex_and_char_morse_keyer_top
// Self-checking bench for the hex and character Morse keyer. A directed
// stimulus table covers the character classes and their boundaries, unknown
// codes, hex bytes and the gap registers at their extremes. A random phase
// follows. Each accepted result is checked against the keying model or its row.
// ----------------------------------------------------------------------------
module tb_hex_and_char_morse_keyer_top;
  import hcmk_pkg::*;

  localparam int RAND_ITEMS  = 136;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_WAIT  = 60;

  // One key result: level, hold time, end-of-item mark
  typedef struct packed {
    logic       key;
    logic [7:0] hold;
    logic       last;
  } key_step_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  // One row of the directed stimulus table
  typedef struct packed {
    row_kind_t  kind;
    logic       reg_idx;
    logic [7:0] reg_val;
    logic       act;
    logic [7:0] code;
    logic       typed;
    key_step_t  want;
  } stim_row_t;

  localparam key_step_t NO_WANT = '{1'b0, 8'd0, 1'b0};

  // Unit patterns, LSB first: digits 0-9, then letters A-Z
  localparam logic [PATTERN_BITS-1:0] UNIT_CODES [36] = '{
    19'h77777, 19'h1DDDD, 19'h07775, 19'h01DD5, 19'h00755,
    19'h00155, 19'h00557, 19'h01577, 19'h05777, 19'h17777,
    19'h0001D, 19'h00157, 19'h005D7, 19'h00057, 19'h00001,
    19'h00175, 19'h00177, 19'h00055, 19'h00005, 19'h01DDD,
    19'h001D7, 19'h0015D, 19'h00077, 19'h00017, 19'h00777,
    19'h005DD, 19'h01D77, 19'h0005D, 19'h00015, 19'h00007,
    19'h00075, 19'h001D5, 19'h001DD, 19'h00757, 19'h01DD7,
    19'h00577
  };

  localparam int STIM_ROWS = 30;

  stim_row_t stim_table [STIM_ROWS] = '{
    // unknown codes right after reset: only the default character gap
    '{ROW_ITEM, CFG_CHAR_GAP, 8'h00, ACT_CHAR, 8'h00, 1'b1, '{1'b0, 8'd3, 1'b1}},
    '{ROW_ITEM, CFG_CHAR_GAP, 8'h00, ACT_CHAR, 8'hFF, 1'b1, '{1'b0, 8'd3, 1'b1}},
    '{ROW_ITEM, CFG_CHAR_GAP, 8'h00, ACT_CHAR, 8'h2F, 1'b1, '{1'b0, 8'd3, 1'b1}},
    '{ROW_ITEM, CFG_CHAR_GAP, 8'h00, ACT_CHAR, 8'h3A, 1'b1, '{1'b0, 8'd3, 1'b1}},
    '{ROW_ITEM, CFG_CHAR_GAP, 8'h00, ACT_CHAR, 8'h40, 1'b1, '{1'b0, 8'd3, 1'b1}},
    '{ROW_ITEM, CFG_CHAR_GAP, 8'h00, ACT_CHAR, 8'h5B, 1'b1, '{1'b0, 8'd3, 1'b1}},
    '{ROW_ITEM, CFG_CHAR_GAP, 8'h00, ACT_CHAR, 8'h60, 1'b1, '{1'b0, 8'd3, 1'b1}},
    '{ROW_ITEM, CFG_CHAR_GAP, 8'h00, ACT_CHAR, 8'h7B, 1'b1, '{1'b0, 8'd3, 1'b1}},
    // class boundaries of digits and both letter cases
    '{ROW_ITEM, CFG_CHAR_GAP, 8'h00, ACT_CHAR, 8'h30, 1'b0, NO_WANT},
    '{ROW_ITEM, CFG_CHAR_GAP, 8'h00, ACT_CHAR, 8'h39, 1'b0, NO_WANT},
    '{ROW_ITEM, CFG_CHAR_GAP, 8'h00, ACT_CHAR, 8'h41, 1'b0, NO_WANT},
    '{ROW_ITEM, CFG_CHAR_GAP, 8'h00, ACT_CHAR, 8'h5A, 1'b0, NO_WANT},
    '{ROW_ITEM, CFG_CHAR_GAP, 8'h00, ACT_CHAR, 8'h61, 1'b0, NO_WANT},
    '{ROW_ITEM, CFG_CHAR_GAP, 8'h00, ACT_CHAR, 8'h7A, 1'b0, NO_WANT},
    '{ROW_ITEM, CFG_CHAR_GAP, 8'h00, ACT_CHAR, 8'h45, 1'b0, NO_WANT},
    // hex bytes at the extremes and mixed nibbles
    '{ROW_ITEM, CFG_CHAR_GAP, 8'h00, ACT_HEX,  8'h00, 1'b0, NO_WANT},
    '{ROW_ITEM, CFG_CHAR_GAP, 8'h00, ACT_HEX,  8'hFF, 1'b0, NO_WANT},
    '{ROW_ITEM, CFG_CHAR_GAP, 8'h00, ACT_HEX,  8'hA5, 1'b0, NO_WANT},
    // widest gaps
    '{ROW_CFG,  CFG_CHAR_GAP, 8'h0F, ACT_CHAR, 8'h00, 1'b0, NO_WANT},
    '{ROW_CFG,  CFG_BYTE_GAP, 8'hFF, ACT_CHAR, 8'h00, 1'b0, NO_WANT},
    '{ROW_ITEM, CFG_CHAR_GAP, 8'h00, ACT_HEX,  8'h00, 1'b0, NO_WANT},
    '{ROW_ITEM, CFG_CHAR_GAP, 8'h00, ACT_CHAR, 8'h21, 1'b1, '{1'b0, 8'd15, 1'b1}},
    // zero gaps count as one unit; upper bits of the char gap are dropped
    '{ROW_CFG,  CFG_CHAR_GAP, 8'hF0, ACT_CHAR, 8'h00, 1'b0, NO_WANT},
    '{ROW_CFG,  CFG_BYTE_GAP, 8'h00, ACT_CHAR, 8'h00, 1'b0, NO_WANT},
    '{ROW_ITEM, CFG_CHAR_GAP, 8'h00, ACT_CHAR, 8'h7F, 1'b1, '{1'b0, 8'd1, 1'b1}},
    '{ROW_ITEM, CFG_CHAR_GAP, 8'h00, ACT_HEX,  8'h5A, 1'b0, NO_WANT},
    // narrowest legal gaps
    '{ROW_CFG,  CFG_CHAR_GAP, 8'h01, ACT_CHAR, 8'h00, 1'b0, NO_WANT},
    '{ROW_CFG,  CFG_BYTE_GAP, 8'h01, ACT_CHAR, 8'h00, 1'b0, NO_WANT},
    '{ROW_ITEM, CFG_CHAR_GAP, 8'h00, ACT_HEX,  8'h3C, 1'b0, NO_WANT},
    '{ROW_ITEM, CFG_CHAR_GAP, 8'h00, ACT_CHAR, 8'h65, 1'b0, NO_WANT}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = 1'b0;
  logic [7:0] cfg_data = 8'd0;
  logic       req_valid = 1'b0;
  logic       req_stall;
  logic       action = 1'b0;
  logic [7:0] data = 8'd0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic       key;
  logic [7:0] hold_units;
  logic       last;

  // Gap settings as the keying model sees them
  logic [3:0] char_gap_set;
  logic [7:0] byte_gap_set;

  key_step_t  pending_keys [$];
  int         bad_results = 0;
  int         cycles = 0;
  bit         quiet_run = 1'b0;

  hex_and_char_morse_keyer_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .action     (action),
    .data       (data),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .key        (key),
    .hold_units (hold_units),
    .last       (last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Look up the unit pattern of an ASCII code; zero when not keyable
  function automatic logic [PATTERN_BITS-1:0] units_of(input logic [7:0] code);
    logic [7:0] up;
    up = (code >= "a" && code <= "z") ? code - 8'd32 : code;
    if (up >= "0" && up <= "9") begin
      return UNIT_CODES[up - "0"];
    end
    if (up >= "A" && up <= "Z") begin
      return UNIT_CODES[up - "A" + 10];
    end
    return '0;
  endfunction

  // Append the unit steps of one character and its trailing gap
  function automatic void key_char(ref key_step_t steps [$], input logic [7:0] code);
    logic [PATTERN_BITS-1:0] pat;
    pat = units_of(code);
    while (pat != '0) begin
      steps.push_back('{pat[0], 8'd1, 1'b0});
      pat = pat >> 1;
    end
    steps.push_back('{1'b0, (char_gap_set == 4'd0) ? 8'd1 : {4'd0, char_gap_set}, 1'b0});
  endfunction

  function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
    return (nib < 4'd10) ? "0" + nib : "A" + (nib - 4'd10);
  endfunction

  // Work out the key steps of one item and queue them for checking
  function automatic void predict_keying(input logic act, input logic [7:0] code);
    key_step_t steps [$];
    if (act == ACT_CHAR) begin
      key_char(steps, code);
    end else begin
      key_char(steps, hex_glyph(code[7:4]));
      key_char(steps, hex_glyph(code[3:0]));
      steps.push_back('{1'b0, (byte_gap_set == 8'd0) ? 8'd1 : byte_gap_set, 1'b0});
    end
    steps[steps.size() - 1].last = 1'b1;
    foreach (steps[i]) begin
      pending_keys.push_back(steps[i]);
    end
  endfunction

  // Offer one item, idling first now and then, and hold it until taken
  task automatic send_item(input logic act, input logic [7:0] code,
                           input logic typed, input key_step_t want);
    cfg_valid <= 1'b0;
    if (!quiet_run && $urandom_range(0, 99) < 12) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_valid <= 1'b1;
    action    <= act;
    data      <= code;
    do @(posedge clk); while (req_stall);
    if (typed) begin
      pending_keys.push_back(want);
    end else begin
      predict_keying(act, code);
    end
  endtask

  // Write a gap register once every pending result is out
  task automatic write_gap(input logic idx, input logic [7:0] val);
    req_valid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_CHAR_GAP) begin
      char_gap_set = val[3:0];
    end else begin
      byte_gap_set = val;
    end
  endtask

  function automatic logic [7:0] pick_gap_value();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      return 8'($urandom_range("A", "Z"));
    end
    if (r < 70) begin
      return 8'($urandom_range("a", "z"));
    end
    if (r < 85) begin
      return 8'($urandom_range("0", "9"));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Stall the result side at random, except during the quiet stretch
  always @(posedge clk) begin
    res_stall <= !quiet_run && ($urandom_range(0, 99) < 12);
  end

  // Compare each accepted result with the oldest pending one
  always @(posedge clk) begin
    key_step_t exp_step;
    if (!rst && res_valid && !res_stall) begin
      if (pending_keys.size() == 0) begin
        bad_results++;
        if (bad_results <= 10) begin
          $display("unexpected result: key %0b hold %0d last %0b", key, hold_units, last);
        end
      end else begin
        exp_step = pending_keys.pop_front();
        if (key !== exp_step.key || hold_units !== exp_step.hold ||
            last !== exp_step.last) begin
          bad_results++;
          if (bad_results <= 10) begin
            $display("mismatch: expected %0b/%0d/%0b got %0b/%0d/%0b (key/hold/last)",
                     exp_step.key, exp_step.hold, exp_step.last, key, hold_units, last);
          end
        end
      end
    end
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_hex_and_char_morse_keyer_top NOT OK");
      $finish;
    end
  end

  initial begin
    logic act;
    char_gap_set = 4'd3;
    byte_gap_set = 8'd7;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_CFG) begin
        write_gap(stim_table[i].reg_idx, stim_table[i].reg_val);
      end else begin
        send_item(stim_table[i].act, stim_table[i].code, stim_table[i].typed,
                  stim_table[i].want);
      end
    end

    // Random items, with gap changes between phases and one quiet stretch
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 40 == 0) begin
        write_gap(CFG_CHAR_GAP, pick_gap_value());
        write_gap(CFG_BYTE_GAP, pick_gap_value());
      end
      quiet_run = (n >= 60 && n < 100);
      act = 1'($urandom_range(0, 1));
      send_item(act, (act == ACT_HEX) ? 8'($urandom_range(0, 255)) : pick_char(),
                1'b0, NO_WANT);
    end
    quiet_run = 1'b0;
    req_valid <= 1'b0;

    // Drain, then watch for stray results
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (bad_results == 0 && pending_keys.size() == 0) begin
      $display("tb_hex_and_char_morse_keyer_top OK");
    end else begin
      $display("tb_hex_and_char_morse_keyer_top NOT OK");
    end
    $finish;
  end

endmodule
